[src/tlpd_pkg.sv]
package tlpd_pkg;

    localparam int LENGTH_DIGITS = 9;
    localparam int LEN_W         = 30;
    localparam int DIGIT_CNT_W   = 4;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // event codes on the result channel
    typedef enum logic [1:0] {
        EV_HEADER   = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_BAD_TYPE = 2'd2,
        EV_LEN_ABRT = 2'd3
    } t_event;

    // register indexes on the config port
    localparam logic REG_ENDPOINT = 1'b0;
    localparam logic REG_RAWDATA  = 1'b1;

    localparam logic [7:0] RST_ENDPOINT = 8'd1;
    localparam logic [7:0] RST_RAWDATA  = 8'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef struct packed {
        logic [7:0] endpoint_code;
        logic [7:0] rawdata_code;
    } t_codes;

    typedef struct packed {
        t_event           event_res;
        logic             msg_kind;
        logic [LEN_W-1:0] msg_length;
        logic [7:0]       data;
        logic             last;
    } t_result;

endpackage

[src/tlpd_regs.sv]
module tlpd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [tlpd_pkg::DATA_W-1:0]   pwdata,
    output logic [tlpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tlpd_pkg::t_codes              o_codes
);
    import tlpd_pkg::*;

    logic [7:0] r_endpoint_code;
    logic [7:0] r_rawdata_code;
    logic       w_wr;
    logic       w_index;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite & pready;
    // word address selects the register, byte offset ignored
    assign w_index = paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_endpoint_code <= RST_ENDPOINT;
            r_rawdata_code  <= RST_RAWDATA;
        end else if (w_wr) begin
            if (w_index == REG_ENDPOINT) begin
                r_endpoint_code <= pwdata[7:0];
            end else begin
                r_rawdata_code <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (w_index == REG_ENDPOINT) begin
            prdata = {{(DATA_W-8){1'b0}}, r_endpoint_code};
        end else begin
            prdata = {{(DATA_W-8){1'b0}}, r_rawdata_code};
        end
    end

    assign o_codes.endpoint_code = r_endpoint_code;
    assign o_codes.rawdata_code  = r_rawdata_code;

endmodule

[src/type_length_payload_deframer.sv]
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+--------------------------------------
// rx in     | input     | i_in_valid / o_in_ready    | i_rx_byte
// result    | output    | o_out_valid / i_out_ready  | o_event_res o_msg_kind o_msg_length
//           |           |                            | o_data o_last
// config    | input     | psel penable pwrite pready | paddr pwdata prdata
//
// one byte is accepted per cycle while o_in_ready is high; its result (if any) is registered
// in the output stage and shown on the result channel from there.
// a two-entry output stage (result register plus skid) lets input continue while a
// result waits; o_in_ready drops only when both entries are full.
// synchronous active-low reset returns to awaiting a type byte and restores the codes.
module type_length_payload_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_event_res,
    output logic                          o_msg_kind,
    output logic [tlpd_pkg::LEN_W-1:0]    o_msg_length,
    output logic [7:0]                    o_data,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [tlpd_pkg::DATA_W-1:0]   pwdata,
    output logic [tlpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import tlpd_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_codes                 w_codes;

    t_phase                 r_phase;
    logic                   r_kind;
    logic [DIGIT_CNT_W-1:0] r_digits_left;
    logic [LEN_W-1:0]       r_length_acc;
    logic [LEN_W-1:0]       r_bytes_left;

    t_phase                 n_phase;
    logic                   n_kind;
    logic [DIGIT_CNT_W-1:0] n_digits_left;
    logic [LEN_W-1:0]       n_length_acc;
    logic [LEN_W-1:0]       n_bytes_left;
    t_result                n_res;
    logic                   n_has_res;

    t_result                r_out;
    logic                   r_out_valid;
    t_result                r_skid;
    logic                   r_skid_valid;

    logic                   w_accept;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_is_digit;
    logic [3:0]             w_digit;
    logic [LEN_W-1:0]       w_acc_next;

    tlpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_codes (w_codes)
    );

    assign o_in_ready = ~r_skid_valid;
    assign w_accept   = i_in_valid & o_in_ready;

    assign w_is_digit = (i_rx_byte >= ASCII_ZERO) && (i_rx_byte <= ASCII_NINE);
    assign w_digit    = 4'(i_rx_byte - ASCII_ZERO);
    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, wrapped to the field width
    assign w_acc_next = LEN_W'({r_length_acc, 3'b000} + {2'b00, r_length_acc, 1'b0}
                               + {{(LEN_W-1){1'b0}}, w_digit});

    always_comb begin
        n_phase       = r_phase;
        n_kind        = r_kind;
        n_digits_left = r_digits_left;
        n_length_acc  = r_length_acc;
        n_bytes_left  = r_bytes_left;
        n_has_res     = 1'b0;
        n_res         = '{event_res: EV_HEADER, msg_kind: r_kind,
                          msg_length: '0, data: i_rx_byte, last: 1'b0};
        case (r_phase)
            PH_LENGTH: begin
                if (!w_is_digit) begin
                    n_has_res       = 1'b1;
                    n_res.event_res = EV_LEN_ABRT;
                    n_phase         = PH_TYPE;
                end else begin
                    n_length_acc = w_acc_next;
                    if (r_digits_left <= DIGIT_CNT_W'(1)) begin
                        n_digits_left = '0;
                        n_has_res     = 1'b1;
                        n_res.data    = '0;
                        if (w_acc_next == '0) begin
                            n_res.last = 1'b1;
                            n_phase    = PH_TYPE;
                        end else begin
                            n_res.msg_length = w_acc_next;
                            n_bytes_left     = w_acc_next;
                            n_phase          = PH_PAYLOAD;
                        end
                    end else begin
                        n_digits_left = r_digits_left - DIGIT_CNT_W'(1);
                    end
                end
            end
            PH_PAYLOAD: begin
                n_has_res       = 1'b1;
                n_res.event_res = EV_PAYLOAD;
                if (r_bytes_left <= LEN_W'(1)) begin
                    n_bytes_left = '0;
                    n_res.last   = 1'b1;
                    n_phase      = PH_TYPE;
                end else begin
                    n_bytes_left = r_bytes_left - LEN_W'(1);
                end
            end
            default: begin
                n_phase = PH_TYPE;
                if (i_rx_byte == w_codes.endpoint_code ||
                    i_rx_byte == w_codes.rawdata_code) begin
                    // endpoint wins when both codes match
                    n_kind        = (i_rx_byte != w_codes.endpoint_code);
                    n_digits_left = DIGIT_CNT_W'(LENGTH_DIGITS);
                    n_length_acc  = '0;
                    n_bytes_left  = '0;
                    n_phase       = PH_LENGTH;
                end else begin
                    n_has_res       = 1'b1;
                    n_res.event_res = EV_BAD_TYPE;
                    n_res.msg_kind  = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TYPE;
            r_kind        <= 1'b0;
            r_digits_left <= DIGIT_CNT_W'(LENGTH_DIGITS);
            r_length_acc  <= '0;
            r_bytes_left  <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_kind        <= n_kind;
            r_digits_left <= n_digits_left;
            r_length_acc  <= n_length_acc;
            r_bytes_left  <= n_bytes_left;
        end
    end

    // result register with one skid entry behind it
    assign w_push = w_accept & n_has_res;
    assign w_pop  = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_out.event_res;
    assign o_msg_kind   = r_out.msg_kind;
    assign o_msg_length = r_out.msg_length;
    assign o_data       = r_out.data;
    assign o_last       = r_out.last;

endmodule
